>>> src/generational_sparse_set_store_assert.svh
// Assertion macros used by the checker of this block.
`ifndef GENERATIONAL_SPARSE_SET_STORE_ASSERT_SVH
`define GENERATIONAL_SPARSE_SET_STORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define GSSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must hold whenever the response channel shows an item.
`define GSSS_RSP_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) rsp_valid |-> (cond)) \
		else $error(msg);

`endif

>>> src/gsss_pkg.sv
package gsss_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int NUM_COMP  = 8;
	localparam int GEN_BITS  = 8;

	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int COMP_W = $clog2(NUM_COMP);
	localparam int ACT_W  = COMP_W + 1;
	localparam int SP_AW  = COMP_W + IDX_W;
	localparam int SP_DEPTH = NUM_COMP * MAX_SLOTS;

	typedef enum logic [2:0] {
		K_CREATE  = 3'd0,
		K_DESTROY = 3'd1,
		K_ADD     = 3'd2,
		K_LOOKUP  = 3'd3,
		K_READ    = 3'd4,
		K_EXISTS  = 3'd5,
		K_COUNT   = 3'd6
	} kind_e;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ABSENT  = 3'd1,
		ST_STALE   = 3'd2,
		ST_BADCOMP = 3'd3,
		ST_PRESENT = 3'd4,
		ST_FULL    = 3'd5
	} status_e;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_EXEC, S_CR_WR, S_RD_GEN,
		S_D_SP, S_D_CHK, S_D_MOVE, S_D_INV, S_D_FIN, S_OUT
	} state_e;

	typedef struct packed {
		logic [2:0]       kind;
		logic [IDX_W-1:0] handle_index;
		logic [7:0]       handle_gen;
		logic [2:0]       component;
		logic [IDX_W-1:0] dense_index;
	} req_t;

	typedef struct packed {
		status_e          status;
		logic [IDX_W-1:0] out_index;
		logic [7:0]       out_gen;
		logic [IDX_W-1:0] dense_pos;
		logic [CNT_W-1:0] member_count;
		logic             exists;
	} rsp_t;

	typedef struct packed {
		logic                active;
		logic [GEN_BITS-1:0] gen;
	} slot_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] pos;
	} sparse_t;

endpackage

>>> src/generational_sparse_set_store.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | gsss_pkg::req_t
// rsp     | out       | rsp_valid/rsp_ready  | gsss_pkg::rsp_t
// cfg     | in        | cfg_we (no wait)     | cfg_data, active component count
//
// One item at a time. Create from the free stack adds S_CR_WR, a valid read dense adds
// S_RD_GEN. A live destroy visits each active component and, for a member, moves the
// last dense entry into its hole; the sequencer walks the components through the
// single sparse port. After reset the sparse table is swept clear, one entry a cycle,
// with req_ready low. cfg writes are taken during the sweep. A finished item waits in
// the result register until the rsp register is free; the sequencer waits in S_OUT.
module generational_sparse_set_store (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  gsss_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output gsss_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic [3:0]      cfg_data
);

	gsss_pkg::state_e state_q, state_d;

	gsss_pkg::req_t item_q, item_d, cur;
	gsss_pkg::rsp_t res_q, res_d, rsp_q, rsp_d;
	logic rsp_valid_q, rsp_valid_d;

	logic [gsss_pkg::CNT_W-1:0]    fresh_q, fresh_d;   // slots below this were ever handed out
	logic [gsss_pkg::CNT_W-1:0]    fc_q, fc_d;         // free stack depth
	logic [gsss_pkg::ACT_W-1:0]    act_q;              // saturated component limit
	logic [gsss_pkg::CNT_W-1:0]    cnt_q [gsss_pkg::NUM_COMP];
	logic [gsss_pkg::CNT_W-1:0]    cnt_d [gsss_pkg::NUM_COMP];
	logic [gsss_pkg::ACT_W-1:0]    c_q, c_d;           // destroy walk position
	logic [gsss_pkg::IDX_W-1:0]    pos_q, pos_d;
	logic [gsss_pkg::IDX_W-1:0]    slot_q, slot_d;
	logic [gsss_pkg::GEN_BITS-1:0] gen_q, gen_d;
	logic [gsss_pkg::SP_AW-1:0]    clr_q, clr_d;

	// memory ports
	logic                          sl_we;
	logic [gsss_pkg::IDX_W-1:0]    sl_waddr, sl_raddr;
	gsss_pkg::slot_t               sl_wdata, sl_rdata;
	logic                          st_we;
	logic [gsss_pkg::IDX_W-1:0]    st_waddr, st_raddr, st_wdata, st_rdata;
	logic                          sp_we;
	logic [gsss_pkg::SP_AW-1:0]    sp_waddr, sp_raddr;
	gsss_pkg::sparse_t             sp_wdata, sp_rdata;
	logic                          dn_we;
	logic [gsss_pkg::SP_AW-1:0]    dn_waddr, dn_raddr;
	logic [gsss_pkg::IDX_W-1:0]    dn_wdata, dn_rdata;

	logic                          live, comp_ok, d_comp_ok, rsp_free;
	logic [gsss_pkg::CNT_W-1:0]    ccnt, dcnt;
	logic [gsss_pkg::COMP_W-1:0]   dc;

	gsss_ram #(.DEPTH(gsss_pkg::MAX_SLOTS), .WIDTH(gsss_pkg::GEN_BITS + 1)) u_slot (
		.clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
		.raddr(sl_raddr), .rdata(sl_rdata)
	);

	gsss_ram #(.DEPTH(gsss_pkg::MAX_SLOTS), .WIDTH(gsss_pkg::IDX_W)) u_stack (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	gsss_ram #(.DEPTH(gsss_pkg::SP_DEPTH), .WIDTH(gsss_pkg::IDX_W + 1)) u_sparse (
		.clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
		.raddr(sp_raddr), .rdata(sp_rdata)
	);

	gsss_ram #(.DEPTH(gsss_pkg::SP_DEPTH), .WIDTH(gsss_pkg::IDX_W)) u_dense (
		.clk(clk), .we(dn_we), .waddr(dn_waddr), .wdata(dn_wdata),
		.raddr(dn_raddr), .rdata(dn_rdata)
	);

	assign req_ready = (state_q == gsss_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	// In idle the memories are addressed straight from the incoming item.
	assign cur = (state_q == gsss_pkg::S_IDLE) ? req : item_q;

	assign dc        = c_q[gsss_pkg::COMP_W-1:0];
	assign ccnt      = cnt_q[item_q.component];
	assign dcnt      = cnt_q[dc];
	assign comp_ok   = {1'b0, item_q.component} < act_q;
	assign d_comp_ok = c_q < act_q;

	// Live handle: slot was handed out, is active and the generation matches.
	// Slots at or above the fresh mark are never read as live, so no clear is needed.
	assign live = ({1'b0, item_q.handle_index} < fresh_q) && sl_rdata.active &&
		(sl_rdata.gen == item_q.handle_gen);

	always_comb begin
		state_d     = state_q;
		item_d      = item_q;
		res_d       = res_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		fresh_d     = fresh_q;
		fc_d        = fc_q;
		cnt_d       = cnt_q;
		c_d         = c_q;
		pos_d       = pos_q;
		slot_d      = slot_q;
		gen_d       = gen_q;
		clr_d       = clr_q;

		sl_we    = 1'b0;
		sl_waddr = item_q.handle_index;
		sl_wdata = '0;
		sl_raddr = cur.handle_index;
		st_we    = 1'b0;
		st_waddr = fc_q[gsss_pkg::IDX_W-1:0];
		st_wdata = item_q.handle_index;
		st_raddr = gsss_pkg::IDX_W'(fc_q - 1'b1);
		sp_we    = 1'b0;
		sp_waddr = {item_q.component, item_q.handle_index};
		sp_wdata = '0;
		sp_raddr = {cur.component, cur.handle_index};
		dn_we    = 1'b0;
		dn_waddr = {item_q.component, ccnt[gsss_pkg::IDX_W-1:0]};
		dn_wdata = item_q.handle_index;
		dn_raddr = {cur.component, cur.dense_index};

		case (state_q)
			gsss_pkg::S_CLR: begin
				sp_we    = 1'b1;
				sp_waddr = clr_q;
				clr_d    = clr_q + 1'b1;
				if (clr_q == gsss_pkg::SP_AW'(gsss_pkg::SP_DEPTH - 1)) begin
					state_d = gsss_pkg::S_IDLE;
				end
			end
			gsss_pkg::S_IDLE: begin
				if (req_valid) begin
					item_d  = req;
					state_d = gsss_pkg::S_EXEC;
				end
			end
			gsss_pkg::S_EXEC: begin
				res_d   = '0;
				state_d = gsss_pkg::S_OUT;
				case (item_q.kind)
					gsss_pkg::K_CREATE: begin
						if (fc_q != '0) begin
							fc_d     = fc_q - 1'b1;
							slot_d   = st_rdata;
							sl_raddr = st_rdata;
							state_d  = gsss_pkg::S_CR_WR;
						end else if (fresh_q < gsss_pkg::CNT_W'(gsss_pkg::MAX_SLOTS)) begin
							sl_we           = 1'b1;
							sl_waddr        = fresh_q[gsss_pkg::IDX_W-1:0];
							sl_wdata.active = 1'b1;
							res_d.out_index = fresh_q[gsss_pkg::IDX_W-1:0];
							fresh_d         = fresh_q + 1'b1;
						end else begin
							res_d.status = gsss_pkg::ST_FULL;
						end
					end
					gsss_pkg::K_DESTROY: begin
						if (live) begin
							gen_d   = sl_rdata.gen;
							c_d     = '0;
							state_d = gsss_pkg::S_D_SP;
						end else begin
							res_d.status = gsss_pkg::ST_STALE;
						end
					end
					gsss_pkg::K_ADD: begin
						if (!live) begin
							res_d.status = gsss_pkg::ST_STALE;
						end else if (!comp_ok) begin
							res_d.status = gsss_pkg::ST_BADCOMP;
						end else if (sp_rdata.valid) begin
							res_d.status = gsss_pkg::ST_PRESENT;
						end else if (ccnt >= gsss_pkg::CNT_W'(gsss_pkg::MAX_SLOTS)) begin
							res_d.status = gsss_pkg::ST_FULL;
						end else begin
							sp_we          = 1'b1;
							sp_wdata.valid = 1'b1;
							sp_wdata.pos   = ccnt[gsss_pkg::IDX_W-1:0];
							dn_we          = 1'b1;
							res_d.dense_pos = ccnt[gsss_pkg::IDX_W-1:0];
							cnt_d[item_q.component] = ccnt + 1'b1;
						end
					end
					gsss_pkg::K_LOOKUP: begin
						if (!comp_ok) begin
							res_d.status = gsss_pkg::ST_BADCOMP;
						end else if (!live) begin
							res_d.status = gsss_pkg::ST_STALE;
						end else if (!sp_rdata.valid) begin
							res_d.status = gsss_pkg::ST_ABSENT;
						end else begin
							res_d.dense_pos = sp_rdata.pos;
						end
					end
					gsss_pkg::K_READ: begin
						if (!comp_ok) begin
							res_d.status = gsss_pkg::ST_BADCOMP;
						end else if ({1'b0, item_q.dense_index} >= ccnt) begin
							res_d.status = gsss_pkg::ST_ABSENT;
						end else begin
							slot_d   = dn_rdata;
							sl_raddr = dn_rdata;
							state_d  = gsss_pkg::S_RD_GEN;
						end
					end
					gsss_pkg::K_EXISTS: begin
						res_d.exists = live;
					end
					gsss_pkg::K_COUNT: begin
						if (comp_ok) begin
							res_d.member_count = ccnt;
						end else begin
							res_d.status = gsss_pkg::ST_BADCOMP;
						end
					end
					default: begin
						res_d.status = gsss_pkg::ST_STALE;
					end
				endcase
			end
			gsss_pkg::S_CR_WR: begin
				sl_we           = 1'b1;
				sl_waddr        = slot_q;
				sl_wdata.active = 1'b1;
				sl_wdata.gen    = sl_rdata.gen;
				res_d.out_index = slot_q;
				res_d.out_gen   = sl_rdata.gen;
				state_d         = gsss_pkg::S_OUT;
			end
			gsss_pkg::S_RD_GEN: begin
				res_d.out_index = slot_q;
				res_d.out_gen   = sl_rdata.gen;
				state_d         = gsss_pkg::S_OUT;
			end
			gsss_pkg::S_D_SP: begin
				sp_raddr = {dc, item_q.handle_index};
				state_d  = d_comp_ok ? gsss_pkg::S_D_CHK : gsss_pkg::S_D_FIN;
			end
			gsss_pkg::S_D_CHK: begin
				if (sp_rdata.valid && dcnt != '0) begin
					pos_d    = sp_rdata.pos;
					dn_raddr = {dc, gsss_pkg::IDX_W'(dcnt - 1'b1)};
					state_d  = gsss_pkg::S_D_MOVE;
				end else begin
					c_d     = c_q + 1'b1;
					state_d = gsss_pkg::S_D_SP;
				end
			end
			gsss_pkg::S_D_MOVE: begin
				// last dense entry fills the hole, its sparse entry follows
				dn_we          = 1'b1;
				dn_waddr       = {dc, pos_q};
				dn_wdata       = dn_rdata;
				sp_we          = 1'b1;
				sp_waddr       = {dc, dn_rdata};
				sp_wdata.valid = 1'b1;
				sp_wdata.pos   = pos_q;
				cnt_d[dc]      = dcnt - 1'b1;
				state_d        = gsss_pkg::S_D_INV;
			end
			gsss_pkg::S_D_INV: begin
				// after the move so a self-move still ends invalid
				sp_we    = 1'b1;
				sp_waddr = {dc, item_q.handle_index};
				c_d      = c_q + 1'b1;
				state_d  = gsss_pkg::S_D_SP;
			end
			gsss_pkg::S_D_FIN: begin
				sl_we        = 1'b1;
				sl_wdata.gen = gen_q + 1'b1;
				if (fc_q < gsss_pkg::CNT_W'(gsss_pkg::MAX_SLOTS)) begin
					st_we = 1'b1;
					fc_d  = fc_q + 1'b1;
				end
				res_d   = '0;
				state_d = gsss_pkg::S_OUT;
			end
			gsss_pkg::S_OUT: begin
				if (rsp_free) begin
					rsp_d       = res_q;
					rsp_valid_d = 1'b1;
					state_d     = gsss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = gsss_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gsss_pkg::S_CLR;
			rsp_valid_q <= 1'b0;
			fresh_q     <= '0;
			fc_q        <= '0;
			act_q       <= '0;
			cnt_q       <= '{default: '0};
			c_q         <= '0;
			clr_q       <= '0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
			fresh_q     <= fresh_d;
			fc_q        <= fc_d;
			cnt_q       <= cnt_d;
			c_q         <= c_d;
			clr_q       <= clr_d;
			if (cfg_we) begin
				act_q <= (cfg_data > 4'(gsss_pkg::NUM_COMP)) ?
					gsss_pkg::ACT_W'(gsss_pkg::NUM_COMP) : gsss_pkg::ACT_W'(cfg_data);
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		res_q  <= res_d;
		rsp_q  <= rsp_d;
		pos_q  <= pos_d;
		slot_q <= slot_d;
		gen_q  <= gen_d;
	end

endmodule

>>> src/gsss_ram.sv
module gsss_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/gsss_checker.sv
`include "generational_sparse_set_store_assert.svh"

module gsss_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input gsss_pkg::rsp_t rsp
);

	// stalled response holds
	`GSSS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp dropped")

	// one item in flight: no accept right after an accept
	`GSSS_ASSERT(a_one_item, req_valid && req_ready |=> !req_ready, "second item taken")

	`GSSS_RSP_CHECK(a_status_code, rsp.status <= gsss_pkg::ST_FULL, "bad status code")

	`GSSS_RSP_CHECK(a_exists_ok, !rsp.exists || rsp.status == gsss_pkg::ST_OK, "exists with error")

endmodule

bind generational_sparse_set_store gsss_checker u_gsss_checker (.*);

>>> tb/sv/generational_sparse_set_store_tb.sv
`timescale 1ns / 100ps

module generational_sparse_set_store_tb;
	import gsss_pkg::*;

	// Kind code that no operation uses; the block answers it as a stale handle.
	localparam logic [2:0] K_UNUSED = 3'd7;
	// Longest destroy walks all 8 components with the entity a member of each; leave margin on top.
	localparam int SETTLE = 60;
	// Clear sweep plus ~1300 items at worst-case latency, gaps and stalls, many times over.
	localparam int CYCLE_LIMIT = 600000;

	logic   clk;
	logic   arst_n;
	logic   req_valid;
	logic   req_ready;
	req_t   req;
	logic   rsp_valid;
	logic   rsp_ready;
	rsp_t   rsp;
	logic   cfg_we;
	logic   [3:0] cfg_data;

	generational_sparse_set_store u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the store: slots, free stack and per-component sets
	// ------------------------------------------------------------------
	int             comp_limit;             // active components, saturated to 8
	bit             slot_live_bit[MAX_SLOTS];
	logic [7:0]     slot_gen[MAX_SLOTS];
	int             fresh_slot;
	logic [9:0]     free_slots[MAX_SLOTS];
	int             free_depth;
	bit             member_vld[NUM_COMP][MAX_SLOTS];
	logic [9:0]     member_pos[NUM_COMP][MAX_SLOTS];
	logic [9:0]     dense_slot[NUM_COMP][MAX_SLOTS];
	int             member_cnt[NUM_COMP];

	rsp_t           pending_rsp[$];         // answers owed by the block, oldest first
	int             errors;
	int             cycles;
	bit             tx_burst;               // sender: no gaps while set
	bit             rx_burst;               // receiver: no stalls while set
	int             rx_hold;                // one long receiver stall, picked up on next draw

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic bit handle_is_live(logic [9:0] idx, logic [7:0] gen);
		return (idx < fresh_slot) && slot_live_bit[idx] && (slot_gen[idx] == gen);
	endfunction

	// Apply one accepted item to the shadow store and return the answer it owes.
	function automatic rsp_t apply_item(req_t r);
		rsp_t       a;
		int         slot;
		int         c;
		int         hole;
		int         last;
		logic [9:0] moved;
		a = '0;
		a.status = ST_OK;
		case (r.kind)
			K_CREATE: begin
				if (free_depth > 0) begin
					free_depth--;
					slot = int'(free_slots[free_depth]);
				end else if (fresh_slot < MAX_SLOTS) begin
					slot = fresh_slot++;
					slot_gen[slot] = '0;
				end else begin
					a.status = ST_FULL;
					return a;
				end
				slot_live_bit[slot] = 1'b1;
				a.out_index = slot[9:0];
				a.out_gen = slot_gen[slot];
			end
			K_DESTROY: begin
				if (!handle_is_live(r.handle_index, r.handle_gen)) begin
					a.status = ST_STALE;
					return a;
				end
				// swap-remove from every active set the entity belongs to
				for (c = 0; c < comp_limit; c++) begin
					if (member_vld[c][r.handle_index] && member_cnt[c] > 0) begin
						hole = int'(member_pos[c][r.handle_index]);
						last = member_cnt[c] - 1;
						moved = dense_slot[c][last];
						dense_slot[c][hole] = moved;
						member_pos[c][moved] = hole[9:0];
						member_cnt[c] = last;
						member_vld[c][r.handle_index] = 1'b0;
					end
				end
				slot_live_bit[r.handle_index] = 1'b0;
				slot_gen[r.handle_index] = slot_gen[r.handle_index] + 8'd1;
				free_slots[free_depth++] = r.handle_index;
			end
			K_ADD: begin
				if (!handle_is_live(r.handle_index, r.handle_gen)) a.status = ST_STALE;
				else if (r.component >= comp_limit) a.status = ST_BADCOMP;
				else if (member_vld[r.component][r.handle_index]) a.status = ST_PRESENT;
				else if (member_cnt[r.component] >= MAX_SLOTS) a.status = ST_FULL;
				else begin
					c = member_cnt[r.component];
					member_pos[r.component][r.handle_index] = c[9:0];
					member_vld[r.component][r.handle_index] = 1'b1;
					dense_slot[r.component][c] = r.handle_index;
					a.dense_pos = c[9:0];
					member_cnt[r.component]++;
				end
			end
			K_LOOKUP: begin
				if (r.component >= comp_limit) a.status = ST_BADCOMP;
				else if (!handle_is_live(r.handle_index, r.handle_gen)) a.status = ST_STALE;
				else if (!member_vld[r.component][r.handle_index]) a.status = ST_ABSENT;
				else a.dense_pos = member_pos[r.component][r.handle_index];
			end
			K_READ: begin
				if (r.component >= comp_limit) a.status = ST_BADCOMP;
				else if (r.dense_index >= member_cnt[r.component]) a.status = ST_ABSENT;
				else begin
					a.out_index = dense_slot[r.component][r.dense_index];
					a.out_gen = slot_gen[a.out_index];
				end
			end
			K_EXISTS: a.exists = handle_is_live(r.handle_index, r.handle_gen);
			K_COUNT: begin
				if (r.component >= comp_limit) a.status = ST_BADCOMP;
				else a.member_count = member_cnt[r.component][10:0];
			end
			default: a.status = ST_STALE;
		endcase
		return a;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	task automatic send_item(input req_t item);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		pending_rsp.push_back(apply_item(item));
	endtask

	// Wait until every answer is in, then let a long destroy finish.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_comp_limit(input logic [3:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		comp_limit = (value > NUM_COMP) ? NUM_COMP : int'(value);
	endtask

	function automatic req_t make_req(logic [2:0] k, logic [9:0] idx, logic [7:0] gen,
			logic [2:0] comp, logic [9:0] di);
		req_t r;
		r.kind = k;
		r.handle_index = idx;
		r.handle_gen = gen;
		r.component = comp;
		r.dense_index = di;
		return r;
	endfunction

	// Handle of some live entity if one can be found quickly, else random bits.
	function automatic void pick_handle(inout req_t r);
		int i;
		int tries;
		r.handle_index = 10'($urandom);
		r.handle_gen = 8'($urandom);
		if (fresh_slot == 0) return;
		for (tries = 0; tries < 16; tries++) begin
			i = $urandom_range(0, fresh_slot - 1);
			if (slot_live_bit[i]) begin
				r.handle_index = i[9:0];
				r.handle_gen = slot_gen[i];
				return;
			end
		end
	endfunction

	// Mostly well-formed operations on live handles; a slice of noise and stale handles.
	function automatic req_t random_req();
		req_t r;
		int   pick;
		r.kind = 3'($urandom);
		r.handle_index = 10'($urandom);
		r.handle_gen = 8'($urandom);
		r.component = 3'($urandom);
		r.dense_index = 10'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 6) return r;                     // pure noise, kind 7 included
		if (pick < 20) r.kind = K_CREATE;
		else if (pick < 33) r.kind = K_DESTROY;
		else if (pick < 58) r.kind = K_ADD;
		else if (pick < 72) r.kind = K_LOOKUP;
		else if (pick < 84) r.kind = K_READ;
		else if (pick < 92) r.kind = K_EXISTS;
		else r.kind = K_COUNT;
		if ($urandom_range(0, 9) < 8) pick_handle(r);
		if ($urandom_range(0, 9) == 0) r.handle_gen = r.handle_gen + 8'd1;   // stale
		if (r.kind == K_READ && $urandom_range(0, 3) != 0)
			r.dense_index = 10'($urandom_range(0, member_cnt[r.component]));
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Response side: random stalls, an occasional long hold, and the check
	// ------------------------------------------------------------------
	initial begin : rsp_side
		int   stall;
		rsp_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end else
				stall = rx_burst ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			if (pending_rsp.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected item: %p", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.out_index !== want.out_index ||
						rsp.out_gen !== want.out_gen || rsp.dense_pos !== want.dense_pos ||
						rsp.member_count !== want.member_count ||
						rsp.exists !== want.exists) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp %s idx %0d gen %0d pos %0d cnt %0d ex %0d / got %s idx %0d gen %0d pos %0d cnt %0d ex %0d",
							want.status.name(), want.out_index, want.out_gen, want.dense_pos,
							want.member_count, want.exists, rsp.status.name(), rsp.out_index,
							rsp.out_gen, rsp.dense_pos, rsp.member_count, rsp.exists);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Corner cases by hand: every kind, every status but full, field extremes.
	task automatic test_directed();
		// written while the clear sweep runs; 15 saturates to all 8 components
		cfg_we <= 1'b1;
		cfg_data <= 4'd15;
		@(posedge clk);
		cfg_we <= 1'b0;
		comp_limit = NUM_COMP;
		send_item(make_req(K_COUNT, 10'd0, 8'd0, 3'd0, 10'd0));
		send_item(make_req(K_CREATE, 10'd0, 8'd0, 3'd0, 10'd0));        // slot 0
		send_item(make_req(K_CREATE, 10'h3FF, 8'hFF, 3'd7, 10'h3FF));   // slot 1
		send_item(make_req(K_EXISTS, 10'd0, 8'd0, 3'd0, 10'd0));
		send_item(make_req(K_EXISTS, 10'd0, 8'hFF, 3'd0, 10'd0));       // wrong gen
		send_item(make_req(K_ADD, 10'd0, 8'd0, 3'd0, 10'd0));
		send_item(make_req(K_ADD, 10'd1, 8'd0, 3'd0, 10'd0));
		send_item(make_req(K_ADD, 10'd0, 8'd0, 3'd0, 10'd0));           // already there
		send_item(make_req(K_ADD, 10'd0, 8'd0, 3'd7, 10'd0));
		send_item(make_req(K_LOOKUP, 10'd1, 8'd0, 3'd0, 10'd0));
		send_item(make_req(K_LOOKUP, 10'd1, 8'd0, 3'd1, 10'd0));        // absent
		send_item(make_req(K_LOOKUP, 10'h3FF, 8'hFF, 3'd0, 10'd0));     // dead handle
		send_item(make_req(K_READ, 10'd0, 8'd0, 3'd0, 10'd1));
		send_item(make_req(K_READ, 10'd0, 8'd0, 3'd0, 10'd2));          // past count
		send_item(make_req(K_READ, 10'd0, 8'd0, 3'd0, 10'h3FF));
		send_item(make_req(K_DESTROY, 10'd0, 8'd0, 3'd0, 10'd0));       // member: swap
		send_item(make_req(K_READ, 10'd0, 8'd0, 3'd0, 10'd0));
		send_item(make_req(K_DESTROY, 10'd0, 8'd0, 3'd0, 10'd0));       // now stale
		send_item(make_req(K_CREATE, 10'd0, 8'd0, 3'd0, 10'd0));        // reuses slot 0
		send_item(make_req(K_ADD, 10'h3FF, 8'hFF, 3'd7, 10'd0));        // never created
		send_item(make_req(K_UNUSED, 10'h3FF, 8'hFF, 3'd7, 10'h3FF));
		send_item(make_req(K_COUNT, 10'd0, 8'd0, 3'd7, 10'd0));
		// no component active: every component is out of range
		write_comp_limit(4'd0);
		send_item(make_req(K_ADD, 10'd0, 8'd1, 3'd0, 10'd0));
		send_item(make_req(K_LOOKUP, 10'd1, 8'd0, 3'd0, 10'd0));
		send_item(make_req(K_READ, 10'd0, 8'd0, 3'd0, 10'd0));
		send_item(make_req(K_COUNT, 10'd0, 8'd0, 3'd0, 10'd0));
		send_item(make_req(K_DESTROY, 10'd1, 8'd0, 3'd0, 10'd0));       // no walk at all
	endtask

	task automatic test_random(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			// alternate stretches with and without idle cycles
			if (i % 48 == 0) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
			end
			send_item(random_req());
		end
		tx_burst = 0;
		rx_burst = 0;
	endtask

	// Receiver holds off while the sender keeps offering, so the block backs up.
	task automatic test_backpressure();
		int i;
		rx_hold = 300;
		for (i = 0; i < 30; i++) send_item(random_req());
		drain();   // sender pauses until the last answer is in
	endtask

	// Use up every slot, then ask for more; then churn on the full store.
	task automatic test_fill();
		int   i;
		req_t r;
		tx_burst = 1;
		while (!(fresh_slot == MAX_SLOTS && free_depth == 0)) begin
			r = make_req(K_CREATE, 10'($urandom), 8'($urandom), 3'($urandom), 10'($urandom));
			send_item(r);
			if ($urandom_range(0, 15) == 0) begin
				r.kind = K_ADD;
				pick_handle(r);
				send_item(r);
			end
		end
		tx_burst = 0;
		for (i = 0; i < 3; i++) send_item(make_req(K_CREATE, 10'd0, 8'd0, 3'd0, 10'd0));
		// every slot index now exists: exists check at the top of the range
		send_item(make_req(K_EXISTS, 10'h3FF, 8'd0, 3'd0, 10'd0));
		test_random(20);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		tx_burst = 0;
		rx_burst = 0;
		rx_hold = 0;
		comp_limit = 0;
		fresh_slot = 0;
		free_depth = 0;
		foreach (slot_live_bit[i]) slot_live_bit[i] = 1'b0;
		foreach (member_cnt[c]) member_cnt[c] = 0;
		foreach (member_vld[c, i]) member_vld[c][i] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		write_comp_limit(4'd8);
		test_random(20);
		write_comp_limit(4'd1);
		test_random(15);
		write_comp_limit(4'd5);
		test_backpressure();
		test_random(10);
		write_comp_limit(4'd9);    // saturates
		test_fill();
		write_comp_limit(4'd3);
		test_random(10);

		drain();
		if (errors == 0 && pending_rsp.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/gsss_pkg.sv
src/gsss_ram.sv
src/generational_sparse_set_store.sv
src/gsss_checker.sv
tb/sv/generational_sparse_set_store_tb.sv
